### hw/rtl/morse_letter_keyer_core_macros.svh
// assertion macros shared by the keyer rtl
`ifndef MORSE_LETTER_KEYER_CORE_MACROS_SVH
`define MORSE_LETTER_KEYER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MLK_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyer assertion failed");
`define MLK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyer assertion failed");
`else
`define MLK_ASSERT_SAME(lbl, ante, cons)
`define MLK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/mlk_pkg.sv
package mlk_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned UnitW     = 16;
  localparam int unsigned DurW      = 18;
  localparam int unsigned NumLetter = 26;

  localparam logic [CharW-1:0] CharA = 8'h61;
  localparam logic [CharW-1:0] CharZ = 8'h7a;

  localparam logic [UnitW-1:0] UnitTicksRst = 16'd100;

  localparam logic LineHigh = 1'b1;
  localparam logic LineLow  = 1'b0;

  // queue between classifier and sequencer
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // index of the final element per letter
  localparam logic [1:0] ElemLast [NumLetter] = '{
    2'd1, 2'd3, 2'd3, 2'd2, 2'd0, 2'd3, 2'd2, 2'd3, 2'd1, 2'd3, 2'd2, 2'd3, 2'd1,
    2'd1, 2'd2, 2'd3, 2'd3, 2'd2, 2'd2, 2'd0, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd3
  };

  // bit i set: element i is a dash
  localparam logic [3:0] ElemDash [NumLetter] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef struct packed {
    logic       letter;
    logic [1:0] last_idx;
    logic [3:0] dash;
  } mlk_desc_t;

  typedef struct packed {
    logic      empty;
    mlk_desc_t head;
  } mlk_q_stat_t;

  function automatic mlk_desc_t mlk_classify(input logic [CharW-1:0] ch);
    mlk_desc_t       d;
    logic [CharW-1:0] off;
    d   = '0;
    off = ch - CharA;
    if (ch >= CharA && ch <= CharZ) begin
      d.letter   = 1'b1;
      d.last_idx = ElemLast[off[4:0]];
      d.dash     = ElemDash[off[4:0]];
    end
    return d;
  endfunction

  function automatic logic [DurW-1:0] mlk_triple(input logic [UnitW-1:0] u);
    return {2'b00, u} + {1'b0, u, 1'b0};
  endfunction

endpackage

### hw/rtl/mlk_front.sv
module mlk_front import mlk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [CharW-1:0] character_i,
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  input  logic             q_full_i,
  output logic             push_o,
  output mlk_desc_t        desc_o,
  output logic [UnitW-1:0] unit_o
);

  logic [UnitW-1:0] unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UnitTicksRst;
    end else if (cfg_we_i) begin
      unit_q <= cfg_wdata_i;
    end
  end

  assign busy   = q_full_i;
  assign push_o = start & ~q_full_i;
  assign desc_o = mlk_classify(character_i);
  assign unit_o = unit_q;

endmodule

### hw/rtl/mlk_queue.sv
`include "morse_letter_keyer_core_macros.svh"

module mlk_queue import mlk_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  mlk_desc_t   desc_i,
  input  logic        pop_i,
  output logic        full_o,
  output mlk_q_stat_t stat_o
);

  mlk_desc_t        mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_pop;

  assign full_o       = (count_q == QCntW'(QDepth));
  assign stat_o.empty = (count_q == '0);
  assign stat_o.head  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i & ~stat_o.empty;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `MLK_ASSERT_SAME(a_no_overflow, push_i, !full_o || do_pop)
  `MLK_ASSERT_SAME(a_count_bound, 1'b1, count_q <= QCntW'(QDepth))
  `MLK_ASSERT_NEXT(a_push_visible, push_i && !do_pop, !stat_o.empty)

endmodule

### hw/rtl/mlk_back.sv
`include "morse_letter_keyer_core_macros.svh"

module mlk_back import mlk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlk_q_stat_t      stat_i,
  input  logic [UnitW-1:0] unit_i,
  output logic             pop_o,
  output logic             seg_valid_o,
  output logic             level_o,
  output logic [DurW-1:0]  duration_o,
  output logic             last_segment_o
);

  logic [1:0]      elem_q, elem_d;
  logic            low_q, low_d;
  logic            seg_valid_q;
  logic            level_q, level_d;
  logic [DurW-1:0] dur_q, dur_d;
  logic            last_q, last_d;
  logic [DurW-1:0] unit_ext, unit_x3;
  logic            fin;

  assign unit_ext = {2'b00, unit_i};
  assign unit_x3  = mlk_triple(unit_i);

  always_comb begin
    elem_d  = elem_q;
    low_d   = low_q;
    level_d = LineLow;
    dur_d   = unit_ext;
    last_d  = 1'b0;
    pop_o   = 1'b0;
    fin     = (elem_q == stat_i.head.last_idx);
    if (!stat_i.empty) begin
      if (!stat_i.head.letter) begin
        // gap of three units
        dur_d  = unit_x3;
        last_d = 1'b1;
        pop_o  = 1'b1;
      end else if (!low_q) begin
        level_d = LineHigh;
        dur_d   = stat_i.head.dash[elem_q] ? unit_x3 : unit_ext;
        low_d   = 1'b1;
      end else begin
        last_d = fin;
        low_d  = 1'b0;
        if (fin) begin
          elem_d = '0;
          pop_o  = 1'b1;
        end else begin
          elem_d = elem_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_q      <= '0;
      low_q       <= 1'b0;
      seg_valid_q <= 1'b0;
    end else begin
      elem_q      <= elem_d;
      low_q       <= low_d;
      seg_valid_q <= ~stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stat_i.empty) begin
      level_q <= level_d;
      dur_q   <= dur_d;
      last_q  <= last_d;
    end
  end

  assign seg_valid_o    = seg_valid_q;
  assign level_o        = level_q;
  assign duration_o     = dur_q;
  assign last_segment_o = last_q;

  `MLK_ASSERT_SAME(a_last_is_low, seg_valid_q && last_q, !level_q)
  `MLK_ASSERT_NEXT(a_mark_then_space, seg_valid_q && level_q, seg_valid_q && !level_q)
  `MLK_ASSERT_SAME(a_mid_letter_busy, low_q, !stat_i.empty)

endmodule

### hw/rtl/morse_letter_keyer_core.sv
// the start transfer writes a queue entry; the first segment strobe then comes from the sequencer output registers
// a letter of n elements gives 2n segments (2 to 8), a mark and a space per element; any other code gives one gap
// a four-entry queue absorbs characters while the sequencer keys earlier ones
// busy is high only while that queue is full; results cannot be held off
// reset: asynchronous active low, clears queue and sequencer, unit_ticks returns to 100
module morse_letter_keyer_core import mlk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // character transfer
  input  logic             start,
  output logic             busy,
  input  logic [CharW-1:0] character_i,
  // unit length register
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  // segment results, one per strobe
  output logic             seg_valid_o,
  output logic             level_o,
  output logic [DurW-1:0]  duration_o,
  output logic             last_segment_o
);

  logic             q_full;
  logic             push;
  logic             pop;
  mlk_desc_t        desc;
  mlk_q_stat_t      q_stat;
  logic [UnitW-1:0] unit;

  // front: holds unit length, looks up the letter pattern
  mlk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .character_i (character_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .desc_o      (desc),
    .unit_o      (unit)
  );

  // decoupling queue of classified characters
  mlk_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .full_o (q_full),
    .stat_o (q_stat)
  );

  // back: walks the elements, one segment per cycle while the queue holds a character, into output registers
  mlk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stat_i         (q_stat),
    .unit_i         (unit),
    .pop_o          (pop),
    .seg_valid_o    (seg_valid_o),
    .level_o        (level_o),
    .duration_o     (duration_o),
    .last_segment_o (last_segment_o)
  );

endmodule
